// ===== src/button_setup_mode_sequencer_assert.svh =====
// Assertion macros shared by the sequencer RTL.
`ifndef BUTTON_SETUP_MODE_SEQUENCER_ASSERT_SVH
`define BUTTON_SETUP_MODE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BSMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define BSMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer assertion failed");

`endif

// ===== src/bsms_pkg.sv =====
package bsms_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_COUNT = 2'd2;

  localparam logic [7:0] HOLD_TICKS_RST = 8'd150;
  localparam logic [6:0] THRESHOLD_RST  = 7'd50;
  localparam logic [3:0] MODE_COUNT_RST = 4'd3;

  typedef enum logic [1:0] {
    IND_OFF      = 2'd0,
    IND_THROTTLE = 2'd1,
    IND_ESC      = 2'd2
  } ind_t;

  typedef enum logic [6:0] {
    PH_IDLE         = 7'b0000001,
    PH_ENTER_WAIT   = 7'b0000010,
    PH_THR_WAIT_REL = 7'b0000100,
    PH_THROTTLE     = 7'b0001000,
    PH_ESC_WAIT_REL = 7'b0010000,
    PH_ESC          = 7'b0100000,
    PH_EXIT_WAIT    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       tick;
    logic       button_pressed;
    logic [6:0] throttle_magnitude;
    logic       throttle_negative;
  } in_t;

  typedef struct packed {
    logic [1:0] setup_indication;
    logic       reverse_flag;
    logic [2:0] current_esc_mode;
    logic       save_request;
  } out_t;

  typedef struct packed {
    logic [7:0] hold_ticks;
    logic [6:0] thr_limit;
    logic [3:0] mode_count;
  } cfg_t;

endpackage

// ===== src/bsms_cfg.sv =====
module bsms_cfg import bsms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_ticks <= HOLD_TICKS_RST;
      cfg_r.thr_limit  <= THRESHOLD_RST;
      cfg_r.mode_count <= MODE_COUNT_RST;
    end else if (we) begin
      // unknown indexes are dropped
      unique case (index)
        CFG_HOLD_TICKS: cfg_r.hold_ticks <= data;
        CFG_THRESHOLD:  cfg_r.thr_limit  <= data[6:0];
        CFG_MODE_COUNT: cfg_r.mode_count <= data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/bsms_fsm.sv =====
module bsms_fsm import bsms_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  in_t  in_data,
  input  cfg_t cfg,
  output out_t result
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] hold_count_r, hold_count_nxt;
  logic       reverse_r, reverse_nxt;
  logic [2:0] esc_mode_r, esc_mode_nxt;
  ind_t       ind_r, ind_nxt;
  logic       save;
  logic [3:0] mode_inc;
  logic [7:0] hold_dec;

  assign mode_inc = {1'b0, esc_mode_r} + 4'd1;
  assign hold_dec = hold_count_r - 8'd1;

  always_comb begin
    phase_nxt      = phase_r;
    hold_count_nxt = hold_count_r;
    reverse_nxt    = reverse_r;
    esc_mode_nxt   = esc_mode_r;
    ind_nxt        = ind_r;
    save           = 1'b0;
    if (in_data.tick) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_data.button_pressed) begin
            phase_nxt      = PH_ENTER_WAIT;
            hold_count_nxt = cfg.hold_ticks;
          end
        end
        PH_ENTER_WAIT: begin
          if (!in_data.button_pressed) begin
            phase_nxt = PH_IDLE;
          end else begin
            hold_count_nxt = hold_dec;
            if (hold_dec == 8'd0) begin
              phase_nxt = PH_THR_WAIT_REL;
              ind_nxt   = IND_THROTTLE;
            end
          end
        end
        PH_THR_WAIT_REL: begin
          if (!in_data.button_pressed) phase_nxt = PH_THROTTLE;
        end
        PH_THROTTLE: begin
          // throttle decision overrides a press in the same tick
          if (in_data.throttle_magnitude > cfg.thr_limit) begin
            if (in_data.throttle_negative) begin
              reverse_nxt = ~reverse_r;
              save        = 1'b1;
            end
            ind_nxt   = IND_OFF;
            phase_nxt = PH_IDLE;
          end else if (in_data.button_pressed) begin
            phase_nxt = PH_ESC_WAIT_REL;
            ind_nxt   = IND_ESC;
          end
        end
        PH_ESC_WAIT_REL: begin
          if (!in_data.button_pressed) phase_nxt = PH_ESC;
        end
        PH_ESC: begin
          if (in_data.button_pressed) begin
            phase_nxt      = PH_EXIT_WAIT;
            hold_count_nxt = cfg.hold_ticks;
          end
        end
        PH_EXIT_WAIT: begin
          if (!in_data.button_pressed) begin
            // short press: step mode, wrap at mode_count or past 7
            if (mode_inc == cfg.mode_count || mode_inc[3]) esc_mode_nxt = 3'd0;
            else esc_mode_nxt = mode_inc[2:0];
            phase_nxt = PH_ESC;
          end else begin
            hold_count_nxt = hold_dec;
            if (hold_dec == 8'd0) begin
              ind_nxt   = IND_OFF;
              phase_nxt = PH_IDLE;
              save      = 1'b1;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      hold_count_r <= 8'd0;
      reverse_r    <= 1'b0;
      esc_mode_r   <= 3'd0;
      ind_r        <= IND_OFF;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      hold_count_r <= hold_count_nxt;
      reverse_r    <= reverse_nxt;
      esc_mode_r   <= esc_mode_nxt;
      ind_r        <= ind_nxt;
    end
  end

  assign result.setup_indication = ind_nxt;
  assign result.reverse_flag     = reverse_nxt;
  assign result.current_esc_mode = esc_mode_nxt;
  assign result.save_request     = save;

endmodule

// ===== src/button_setup_mode_sequencer.sv =====
// Channel  | Ports                                | Moves
// ---------+--------------------------------------+-------------------------------
// input    | in_valid, in_ready, in_data (in_t)   | one sample per transaction
// result   | out_valid, out_ready, out_data       | one result per input sample
// config   | cfg_we, cfg_index, cfg_data          | register write, no handshake
//
// One transaction per clock sustained while out_ready stays high; a sample's
// result becomes valid once it has passed the input register and then the
// result register, and is held there until out_ready takes it.
// The phase/counter update loop in bsms_fsm closes through its state registers alone.
// Reset (rst_n low, synchronous) empties both stages, restores config
// defaults and puts the sequencer in idle with flags cleared.
// A stalled result stage holds the input stage; the input register still
// takes a sample whenever it is empty or moving on.
module button_setup_mode_sequencer import bsms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "button_setup_mode_sequencer_assert.svh"

  cfg_t cfg;
  out_t result;

  // input stage
  logic s1_valid_r, s1_valid_nxt;
  in_t  s1_data_r;
  // result stage
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  logic s1_adv;
  logic in_accept;

  // the input stage moves on when the result stage is empty or draining
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_accept = in_valid && in_ready;

  bsms_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // state advances exactly once per sample, as it enters the result stage
  bsms_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_adv),
    .in_data (s1_data_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_adv) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_accept) s1_data_r <= in_data;
    if (s1_adv) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a save only ever coincides with leaving setup
  `BSMS_ASSERT_NOW(a_save_setup_off, out_valid_r && out_data_r.save_request, out_data_r.setup_indication == IND_OFF)
  // a sample without tick never requests a save
  `BSMS_ASSERT_NEXT(a_no_tick_no_save, s1_adv && !s1_data_r.tick, !out_data_r.save_request)
  // a sample moving out of the input stage always lands in the result stage
  `BSMS_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_r)
  // an empty result stage never blocks the input
  `BSMS_ASSERT_NOW(a_ready_when_empty, !out_valid_r, in_ready)

endmodule
